@@ hw/rtl/pam_pkg.sv @@
// shared types and constants for the pixel alpha merge pipeline
// no dependencies; imported by pam_channel and pixel_alpha_merge
package pam_pkg;

   // channel width and opaque level
   localparam int unsigned CH_W = 8;
   localparam logic [CH_W-1:0] CH_MAX = 8'hFF;

   // blend weights are products of two channels
   localparam int unsigned WGT_W = 2 * CH_W;

   // blend numerator, at most 255 * 65025, fits in 24 bits
   localparam int unsigned NUM_W = 24;

   // divide by 255*255 through a reciprocal: floor(n/d) == (n*ceil(2^40/d)) >> 40
   // holds for every n below 2^24 because ceil error stays below 2^16
   localparam int unsigned BLEND_DEN = 65025;
   localparam int unsigned RECIP_SHIFT = 40;
   localparam int unsigned RECIP_W = 25;
   localparam int unsigned PROD_W = NUM_W + RECIP_W;
   localparam logic [RECIP_W-1:0] BLEND_RECIP =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(BLEND_DEN) - 64'd1) / 64'(BLEND_DEN));

   // load enables of the per-channel stages
   typedef struct packed {
      logic prod;
      logic sum;
      logic recip;
   } pam_stage_en_type;

endpackage

@@ hw/rtl/pam_channel.sv @@
// one colour channel of the blend datapath: products, sum, reciprocal divide
// depends on pam_pkg
module pam_channel (
   input  logic                      clock,
   input  pam_pkg::pam_stage_en_type stage_en,
   input  logic [pam_pkg::CH_W-1:0]  src_chan,
   input  logic [pam_pkg::CH_W-1:0]  dst_chan,
   input  logic [pam_pkg::WGT_W-1:0] dst_wgt,
   input  logic [pam_pkg::WGT_W-1:0] src_wgt,
   output logic [pam_pkg::CH_W-1:0]  blend_chan,
   output logic [pam_pkg::CH_W-1:0]  src_chan_out
);
   import pam_pkg::*;

   logic [NUM_W-1:0]  dst_prod_ff, dst_prod_in;
   logic [NUM_W-1:0]  src_prod_ff, src_prod_in;
   logic [CH_W-1:0]   src2_ff;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [CH_W-1:0]   src3_ff;
   logic [PROD_W-1:0] quot_ff, quot_in;
   logic [CH_W-1:0]   src4_ff;

   // channel times weight, both sides
   assign dst_prod_in = NUM_W'(dst_chan * dst_wgt);
   assign src_prod_in = NUM_W'(src_chan * src_wgt);

   // numerator, cannot overflow 24 bits
   assign num_in = dst_prod_ff + src_prod_ff;

   // scaled quotient
   assign quot_in = PROD_W'(num_ff * BLEND_RECIP);

   always_ff @(posedge clock) begin
      if (stage_en.prod) begin
         dst_prod_ff <= dst_prod_in;
         src_prod_ff <= src_prod_in;
         src2_ff     <= src_chan;
      end
      if (stage_en.sum) begin
         num_ff  <= num_in;
         src3_ff <= src2_ff;
      end
      if (stage_en.recip) begin
         quot_ff <= quot_in;
         src4_ff <= src3_ff;
      end
   end

   // quotient never exceeds 255
   assign blend_chan   = quot_ff[RECIP_SHIFT +: CH_W];
   assign src_chan_out = src4_ff;

endmodule

@@ hw/rtl/pixel_alpha_merge.sv @@
// top level of the pixel alpha merge block: handshake, weights, flags, output
// depends on pam_pkg and pam_channel
//
// Merges one source RGBA8888 pixel over one destination pixel per word.
// Input channel req_*: tdata carries the source pixel in the low 32 bits and
// the destination pixel in the high 32 bits, red in the lowest byte of each.
// Result channel rsp_*: tdata carries the merged pixel, tuser the write flag.
// An opaque source, or a visible source over an empty destination, passes
// through; a fully transparent source gives a zero pixel with the flag low;
// anything else is blended exactly as floor of the weighted sum over 65025.
// Throughput: one pixel per clock while the receiver does not stall, set by five
// register stages (weights, channel products, sum, reciprocal multiply,
// output select) that each take a new word every cycle while not stalled.
// Reset empties every stage at once; no word is in flight after it.
// When the receiver stalls, each stage holds only while the stage after it is
// full, so bubbles close up and the input keeps taking words until the
// whole pipeline is full.
module pixel_alpha_merge (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // src_red, src_green, src_blue, src_alpha, dst_red, dst_green, dst_blue, dst_alpha
   input  logic [63:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_red, out_green, out_blue, out_alpha
   output logic [31:0] rsp_tdata,
   // write_enable
   output logic [0:0]  rsp_tuser
);
   import pam_pkg::*;

   logic [CH_W-1:0] in_src [3];
   logic [CH_W-1:0] in_dst [3];
   logic [CH_W-1:0] in_sa, in_da;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5;

   logic [CH_W-1:0]  src1_ff [3];
   logic [CH_W-1:0]  dst1_ff [3];
   logic [WGT_W-1:0] dst_wgt_ff, dst_wgt_in;
   logic [WGT_W-1:0] src_wgt_ff, src_wgt_in;

   logic [CH_W-1:0] alpha1_ff, alpha1_in, alpha2_ff, alpha3_ff, alpha4_ff;
   logic pass1_ff, pass1_in, pass2_ff, pass3_ff, pass4_ff;
   logic we1_ff, we1_in, we2_ff, we3_ff, we4_ff;

   logic [CH_W-1:0] blend_chan [3];
   logic [CH_W-1:0] src_chan4 [3];
   logic [31:0]     out_data_ff, out_data_in;
   logic            out_we_ff;

   pam_stage_en_type stage_en;

   // unpack the input word
   assign in_src[0] = req_tdata[7:0];
   assign in_src[1] = req_tdata[15:8];
   assign in_src[2] = req_tdata[23:16];
   assign in_sa     = req_tdata[31:24];
   assign in_dst[0] = req_tdata[39:32];
   assign in_dst[1] = req_tdata[47:40];
   assign in_dst[2] = req_tdata[55:48];
   assign in_da     = req_tdata[63:56];

   // a stage loads when it is empty or the next one loads
   assign rdy5 = !v5_ff || rsp_tready;
   assign rdy4 = !v4_ff || rdy5;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_tready = rdy1;

   assign stage_en.prod  = rdy2;
   assign stage_en.sum   = rdy3;
   assign stage_en.recip = rdy4;

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_tvalid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
      end
   end

   // blend weights and pixel class
   always_comb begin
      dst_wgt_in = WGT_W'((CH_MAX - in_sa) * in_da);
      src_wgt_in = WGT_W'(in_sa * CH_MAX);
      we1_in     = (in_sa != '0);
      pass1_in   = (in_sa == CH_MAX) || ((in_da == '0) && we1_in);
      if (pass1_in) begin
         alpha1_in = in_sa;
      end else begin
         alpha1_in = (in_sa > in_da) ? in_sa : in_da;
      end
   end

   // stage one and flag line
   always_ff @(posedge clock) begin
      if (rdy1) begin
         src1_ff    <= in_src;
         dst1_ff    <= in_dst;
         dst_wgt_ff <= dst_wgt_in;
         src_wgt_ff <= src_wgt_in;
         alpha1_ff  <= alpha1_in;
         pass1_ff   <= pass1_in;
         we1_ff     <= we1_in;
      end
      if (rdy2) begin
         alpha2_ff <= alpha1_ff;
         pass2_ff  <= pass1_ff;
         we2_ff    <= we1_ff;
      end
      if (rdy3) begin
         alpha3_ff <= alpha2_ff;
         pass3_ff  <= pass2_ff;
         we3_ff    <= we2_ff;
      end
      if (rdy4) begin
         alpha4_ff <= alpha3_ff;
         pass4_ff  <= pass3_ff;
         we4_ff    <= we3_ff;
      end
   end

   // one datapath per colour channel
   for (genvar c = 0; c < 3; c++) begin : g_chan
      pam_channel u_chan (
         .clock        (clock),
         .stage_en     (stage_en),
         .src_chan     (src1_ff[c]),
         .dst_chan     (dst1_ff[c]),
         .dst_wgt      (dst_wgt_ff),
         .src_wgt      (src_wgt_ff),
         .blend_chan   (blend_chan[c]),
         .src_chan_out (src_chan4[c])
      );
   end

   // output select
   always_comb begin
      priority if (!we4_ff) begin
         out_data_in = '0;
      end else if (pass4_ff) begin
         out_data_in = {alpha4_ff, src_chan4[2], src_chan4[1], src_chan4[0]};
      end else begin
         out_data_in = {alpha4_ff, blend_chan[2], blend_chan[1], blend_chan[0]};
      end
   end

   always_ff @(posedge clock) begin
      if (rdy5) begin
         out_data_ff <= out_data_in;
         out_we_ff   <= we4_ff;
      end
   end

   assign rsp_tvalid   = v5_ff;
   assign rsp_tdata    = out_data_ff;
   assign rsp_tuser[0] = out_we_ff;

endmodule

@@ hw/rtl/pam_checker.sv @@
// port-level checks for the pixel alpha merge block, bound to its top level
// depends on pixel_alpha_merge ports only
module pam_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [0:0]  rsp_tuser
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // a stalled result keeps its word
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // no write means an all-zero pixel
   a_skip_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == 32'd0)
      else $error("skipped pixel carries data");

   // a written pixel is never fully transparent
   a_write_alpha: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[31:24] != 8'd0)
      else $error("written pixel has zero alpha");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind pixel_alpha_merge pam_checker u_pam_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
